@@ sv/bpa_pkg.sv @@
// Shared constants, types and helper functions of the bitmap page allocator.
package bpa_pkg;

  // Bitmap geometry.
  localparam int MAX_PAGES = 4096;
  localparam int WORD_W    = 64;
  localparam int WORDS     = MAX_PAGES / WORD_W;
  localparam int WADDR_W   = $clog2(WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int BITCNT_W  = BIT_W + 1;

  // Field widths.
  localparam int ADDR_W = 36;
  localparam int CNT_W  = 13;
  localparam int RUN_W  = CNT_W + 1;
  localparam int TOP_W  = ADDR_W + 1;

  // Configuration register indexes.
  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_TOTAL_PAGES = 1'b1;

  // Request kinds.
  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_UNMAP = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HINT,
    S_FIT,
    S_COMMIT,
    S_UNMAP,
    S_RESP
  } state_e;

  // Result of the first-fit scan over one bitmap word.
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
    logic [CNT_W-1:0] carry;
  } fit_t;

  // Number of set bits in one bitmap word.
  function automatic logic [BITCNT_W-1:0] popcount(input logic [WORD_W-1:0] w);
    logic [BITCNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + BITCNT_W'(w[i]);
    end
    return c;
  endfunction

endpackage

@@ sv/bitmap_page_allocator.sv @@
// Bitmap page allocator: request sequencer, word scan datapath and stream ports.
// Each request is decoded, then makes up to three bitmap passes, each reading one 64-page word
// ahead through the registered read port while it processes the word read before, then waits
// in the response state until the output register is free. An unmap or fixed map makes one pass,
// a hinted map that falls back to first fit all three (hint check, search, write-back), through
// the single read port of the allocation bitmap memory. One request is in flight at a time.
// Reset clears the bitmaps through per-word valid bits at once; no clearing pass is needed.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,   // page_addr[35:0], page_count[48:36]
  input  logic [2:0]        s_axis_tuser,   // req_type[0], fixed[1], zero_request[2]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata,   // result_page[35:0], pages_in_use[48:36]
  output logic [2:0]        m_axis_tuser    // status[1:0], need_zero[2]
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  base_q;
  logic [CNT_W-1:0]   total_q;

  logic               type_q, fixed_q, zreq_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CNT_W-1:0]   n_q;

  logic [CNT_W-1:0]   size_q, size_d;
  logic [TOP_W-1:0]   top_q, top_d;
  logic [IDX_W-1:0]   idx_q, idx_d, hi_q, hi_d;
  logic [WADDR_W-1:0] ptr_q, ptr_d, cur_w_q, cur_w_d, end_w_q, end_w_d;
  logic               proc_q, proc_d;
  logic               busy_q, busy_d, nz_q, nz_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, carry_q, carry_d, used_q, used_d;

  logic [1:0]         res_st_q, res_st_d;
  logic [ADDR_W-1:0]  res_page_q, res_page_d;
  logic               res_nz_q, res_nz_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_st_q, out_st_d;
  logic [ADDR_W-1:0]  out_page_q, out_page_d;
  logic               out_nz_q, out_nz_d;
  logic [CNT_W-1:0]   out_used_q, out_used_d;

  logic [WORD_W-1:0]  alloc_rd, fresh_rd, alloc_wd, fresh_wd;
  logic               alloc_we, fresh_we;
  logic [WORD_W-1:0]  rmask, smask;
  fit_t               fit;

  // Decode arithmetic on the latched request.
  logic [CNT_W-1:0]   size_c;
  logic [TOP_W-1:0]   top_c, end_c;
  logic               inreg_c;
  logic [IDX_W-1:0]   idx_c, hi_c;
  logic [IDX_W-1:0]   fit_idx, fit_hi;
  logic [IDX_W-1:0]   size_m1;
  logic               word_last;
  logic [CNT_W-1:0]   cur_cnt, cnt_sum;
  logic               cur_busy, cur_nz, res_ready;

  assign size_c  = (total_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_q;
  assign top_c   = TOP_W'(base_q) + TOP_W'(size_c);
  assign end_c   = TOP_W'(addr_q) + TOP_W'(n_q);
  assign inreg_c = (addr_q >= base_q) && (end_c <= top_c);
  assign idx_c   = IDX_W'(top_c - end_c);
  assign hi_c    = IDX_W'(RUN_W'(idx_c) + RUN_W'(n_q) - RUN_W'(1));
  assign size_m1 = IDX_W'(size_c - CNT_W'(1));

  // End and start of the free run found by the scan.
  assign fit_hi  = {cur_w_q, fit.pos};
  assign fit_idx = IDX_W'(RUN_W'(fit_hi) + RUN_W'(1) - RUN_W'(n_q));

  // Range and size masks of the word in hand.
  always_comb begin
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int p = 0; p < WORD_W; p++) begin
      pos      = {cur_w_q, BIT_W'(p)};
      rmask[p] = (pos >= idx_q) && (pos <= hi_q);
      smask[p] = CNT_W'(pos) < size_q;
    end
  end

  assign cur_cnt   = CNT_W'(popcount(alloc_rd & rmask));
  assign cnt_sum   = cnt_q + cur_cnt;
  assign cur_busy  = |(alloc_rd & rmask);
  assign cur_nz    = |(~fresh_rd & rmask);
  assign word_last = proc_q && (cur_w_q == end_w_q);
  assign res_ready = !out_valid_q || m_axis_tready;

  bpa_fit u_fit (
    .free_i  (~alloc_rd & smask),
    .carry_i (carry_q),
    .count_i (n_q),
    .fit_o   (fit)
  );

  // Bitmap write-back.
  assign alloc_we = proc_q && ((state_q == S_COMMIT) || (state_q == S_UNMAP));
  assign fresh_we = proc_q && (state_q == S_COMMIT);
  assign alloc_wd = (state_q == S_COMMIT) ? (alloc_rd | rmask) : (alloc_rd & ~rmask);
  assign fresh_wd = fresh_rd & ~rmask;

  bpa_word_ram #(.RESET_BIT(1'b0)) u_alloc_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (ptr_q),
    .rdata_o (alloc_rd),
    .we_i    (alloc_we),
    .waddr_i (cur_w_q),
    .wdata_i (alloc_wd)
  );

  bpa_word_ram #(.RESET_BIT(1'b1)) u_fresh_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (ptr_q),
    .rdata_o (fresh_rd),
    .we_i    (fresh_we),
    .waddr_i (cur_w_q),
    .wdata_i (fresh_wd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (n_q == '0) begin
          state_d = S_RESP;
        end else if (type_q == REQ_UNMAP) begin
          state_d = inreg_c ? S_UNMAP : S_RESP;
        end else if (fixed_q) begin
          state_d = inreg_c ? S_COMMIT : S_RESP;
        end else if ((addr_q != '0) && inreg_c) begin
          state_d = S_HINT;
        end else if (size_c == '0) begin
          state_d = S_RESP;
        end else begin
          state_d = S_FIT;
        end
      end
      S_HINT: begin
        if (word_last) state_d = (busy_q || cur_busy) ? S_FIT : S_COMMIT;
      end
      S_FIT: begin
        if (proc_q && fit.hit) begin
          state_d = S_COMMIT;
        end else if (word_last) begin
          state_d = S_RESP;
        end
      end
      S_COMMIT, S_UNMAP: begin
        if (word_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    size_d      = size_q;
    top_d       = top_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    cur_w_d     = cur_w_q;
    end_w_d     = end_w_q;
    proc_d      = 1'b0;
    busy_d      = busy_q;
    nz_d        = nz_q;
    cnt_d       = cnt_q;
    carry_d     = carry_q;
    used_d      = used_q;
    res_st_d    = res_st_q;
    res_page_d  = res_page_q;
    res_nz_d    = res_nz_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_st_d    = out_st_q;
    out_page_d  = out_page_q;
    out_nz_d    = out_nz_q;
    out_used_d  = out_used_q;
    s_axis_tready = (state_q == S_IDLE);

    // Word pipeline of the passes: read ahead one word, process the one read before.
    if ((state_q == S_HINT) || (state_q == S_FIT) ||
        (state_q == S_COMMIT) || (state_q == S_UNMAP)) begin
      proc_d  = 1'b1;
      cur_w_d = ptr_q;
      ptr_d   = (ptr_q == end_w_q) ? ptr_q : ptr_q + WADDR_W'(1);
    end

    unique case (state_q)
      S_DECODE: begin
        size_d     = size_c;
        top_d      = top_c;
        idx_d      = idx_c;
        hi_d       = hi_c;
        ptr_d      = idx_c[IDX_W-1:BIT_W];
        end_w_d    = hi_c[IDX_W-1:BIT_W];
        busy_d     = 1'b0;
        nz_d       = 1'b0;
        cnt_d      = '0;
        carry_d    = '0;
        res_st_d   = ST_OK;
        res_page_d = '0;
        res_nz_d   = 1'b0;
        if (n_q == '0) begin
          res_st_d = ST_INVALID;
        end else if (type_q == REQ_UNMAP) begin
          if (!inreg_c) res_st_d = ST_INVALID;
        end else if (fixed_q) begin
          if (!inreg_c) res_st_d = ST_NOMEM;
        end else if (!((addr_q != '0) && inreg_c)) begin
          ptr_d   = '0;
          end_w_d = size_m1[IDX_W-1:BIT_W];
          if (size_c == '0) res_st_d = ST_NOMEM;
        end
      end
      S_HINT: begin
        if (proc_q) busy_d = busy_q || cur_busy;
        if (word_last) begin
          proc_d = 1'b0;
          if (busy_q || cur_busy) begin
            ptr_d   = '0;
            end_w_d = size_m1[IDX_W-1:BIT_W];
          end else begin
            ptr_d = idx_q[IDX_W-1:BIT_W];
          end
        end
      end
      S_FIT: begin
        if (proc_q) carry_d = fit.carry;
        if (proc_q && fit.hit) begin
          proc_d  = 1'b0;
          idx_d   = fit_idx;
          hi_d    = fit_hi;
          ptr_d   = fit_idx[IDX_W-1:BIT_W];
          end_w_d = cur_w_q;
        end else if (word_last) begin
          res_st_d = ST_NOMEM;
        end
      end
      S_COMMIT: begin
        if (proc_q) begin
          cnt_d = cnt_sum;
          nz_d  = nz_q || cur_nz;
        end
        if (word_last) begin
          used_d     = used_q + n_q - cnt_sum;
          res_page_d = ADDR_W'(top_q - TOP_W'(idx_q) - TOP_W'(n_q));
          res_nz_d   = zreq_q && (nz_q || cur_nz);
        end
      end
      S_UNMAP: begin
        if (proc_q) cnt_d = cnt_sum;
        if (word_last) used_d = used_q - cnt_sum;
      end
      S_RESP: begin
        if (res_ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_page_d  = res_page_q;
          out_nz_d    = res_nz_q;
          out_used_d  = used_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= ADDR_W'(1);
      total_q     <= CNT_W'(MAX_PAGES);
      used_q      <= '0;
      proc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      proc_q      <= proc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REGION_BASE: base_q  <= cfg_data_i;
          CFG_TOTAL_PAGES: total_q <= cfg_data_i[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      addr_q  <= s_axis_tdata[ADDR_W-1:0];
      n_q     <= s_axis_tdata[ADDR_W +: CNT_W];
      type_q  <= s_axis_tuser[0];
      fixed_q <= s_axis_tuser[1];
      zreq_q  <= s_axis_tuser[2];
    end
    size_q     <= size_d;
    top_q      <= top_d;
    idx_q      <= idx_d;
    hi_q       <= hi_d;
    ptr_q      <= ptr_d;
    cur_w_q    <= cur_w_d;
    end_w_q    <= end_w_d;
    busy_q     <= busy_d;
    nz_q       <= nz_d;
    cnt_q      <= cnt_d;
    carry_q    <= carry_d;
    res_st_q   <= res_st_d;
    res_page_q <= res_page_d;
    res_nz_q   <= res_nz_d;
    out_st_q   <= out_st_d;
    out_page_q <= out_page_d;
    out_nz_q   <= out_nz_d;
    out_used_q <= out_used_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_used_q, out_page_q};
  assign m_axis_tuser  = {out_nz_q, out_st_q};

endmodule

@@ sv/bpa_word_ram.sv @@
// Bitmap word memory with one valid bit per word; an unwritten word reads as its reset pattern.
module bpa_word_ram
  import bpa_pkg::*;
#(
  parameter logic RESET_BIT = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0]  rdata_o,
  input  logic               we_i,
  input  logic [WADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0]  wdata_i
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [WORDS-1:0]  valid_q;
  logic              rvalid_q;

  // Storage array: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Word valid bits, cleared at once by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : {WORD_W{RESET_BIT}};

endmodule

@@ sv/bpa_fit.sv @@
// First-fit scan of one bitmap word, continuing a free run carried from earlier words.
module bpa_fit
  import bpa_pkg::*;
(
  input  logic [WORD_W-1:0] free_i,
  input  logic [CNT_W-1:0]  carry_i,
  input  logic [CNT_W-1:0]  count_i,
  output fit_t              fit_o
);

  // Track the last occupied bit and the run length ending at each bit.
  always_comb begin
    logic             seen;
    logic [BIT_W-1:0] last;
    logic [RUN_W-1:0] run;
    seen  = 1'b0;
    last  = '0;
    run   = '0;
    fit_o = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (!free_i[j]) begin
        seen = 1'b1;
        last = BIT_W'(j);
      end
      run = seen ? (RUN_W'(j) - RUN_W'(last))
                 : (RUN_W'(carry_i) + RUN_W'(j) + RUN_W'(1));
      if (!fit_o.hit && (run >= RUN_W'(count_i))) begin
        fit_o.hit = 1'b1;
        fit_o.pos = BIT_W'(j);
      end
    end
    fit_o.carry = run[CNT_W-1:0];
  end

endmodule

@@ test/tb.sv @@
// Self-checking testbench of the bitmap page allocator: directed table, then random requests.
module tb;
  import bpa_pkg::*;

  // Clock, reset and ports.
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CFG_REGION_BASE;
  logic [ADDR_W-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata = '0;   // page_addr[35:0], page_count[48:36]
  logic [2:0]        s_axis_tuser = '0;   // req_type[0], fixed[1], zero_request[2]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [55:0]       m_axis_tdata;        // result_page[35:0], pages_in_use[48:36]
  logic [2:0]        m_axis_tuser;        // status[1:0], need_zero[2]

  typedef struct packed {
    logic             kind;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic             fix;
    logic             zreq;
  } page_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page;
    logic              nz;
    logic [CNT_W-1:0]  in_use;
  } page_rsp_t;

  // A directed row: request, whether the response is typed in, and that response.
  typedef struct packed {
    page_req_t req;
    logic      typed;
    page_rsp_t rsp;
  } dir_row_t;

  bitmap_page_allocator dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the allocator state.
  logic [ADDR_W-1:0] base_q;
  logic [CNT_W-1:0]  total_q;
  logic              used_map [MAX_PAGES];
  logic              fresh_map[MAX_PAGES];
  int unsigned       busy_pages;

  page_rsp_t expected_rsps[$];
  int        n_errors = 0;
  int        n_rsps = 0;
  bit        stim_done = 1'b0;
  int        idle_pct = 11;
  bit        sink_calm = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d (response %0d)", what, got, want, n_rsps);
    n_errors++;
  endtask

  function automatic longint unsigned region_size();
    return (total_q > MAX_PAGES) ? MAX_PAGES : total_q;
  endfunction

  function automatic bit fits_region(longint unsigned a, longint unsigned n);
    return a >= base_q && a + n <= base_q + region_size();
  endfunction

  function automatic int unsigned bits_set(input bit fresh, longint unsigned idx,
                                           longint unsigned n);
    int unsigned c = 0;
    for (longint unsigned i = 0; i < n; i++)
      if (idx + i < MAX_PAGES)
        c += fresh ? fresh_map[idx + i] : used_map[idx + i];
    return c;
  endfunction

  // Computes the response of one request and updates the mirror.
  function automatic page_rsp_t allocate_page_range(page_req_t r);
    page_rsp_t       o = '0;
    longint unsigned sz = region_size();
    longint unsigned idx = 0, run = 0;
    bit              ok = 0;
    int unsigned     replaced = 0;
    if (r.cnt == 0) begin
      o.status = ST_INVALID;
    end else if (r.kind == REQ_UNMAP) begin
      if (!fits_region(r.addr, r.cnt)) begin
        o.status = ST_INVALID;
      end else begin
        idx = base_q + sz - r.addr - r.cnt;
        busy_pages -= bits_set(0, idx, r.cnt);
        for (longint unsigned i = 0; i < r.cnt; i++)
          if (idx + i < MAX_PAGES) used_map[idx + i] = 0;
      end
    end else begin
      if (r.fix) begin
        if (fits_region(r.addr, r.cnt)) begin
          idx = base_q + sz - r.addr - r.cnt;
          replaced = bits_set(0, idx, r.cnt);
          o.page = r.addr;
          ok = 1;
        end else begin
          o.status = ST_NOMEM;
        end
      end else begin
        if (r.addr != 0 && fits_region(r.addr, r.cnt)) begin
          idx = base_q + sz - r.addr - r.cnt;
          if (bits_set(0, idx, r.cnt) == 0) begin
            o.page = r.addr;
            ok = 1;
          end
        end
        // First fit from the top page down.
        for (longint unsigned i = 0; i < sz && !ok; i++) begin
          run = used_map[i] ? 0 : run + 1;
          if (run == r.cnt) begin
            idx = i + 1 - r.cnt;
            o.page = (base_q + sz - 1) - (idx + r.cnt - 1);
            ok = 1;
          end
        end
        if (!ok) o.status = ST_NOMEM;
      end
      if (ok) begin
        o.nz = r.zreq && bits_set(1, idx, r.cnt) != r.cnt;
        for (longint unsigned i = 0; i < r.cnt; i++)
          if (idx + i < MAX_PAGES) begin
            used_map[idx + i] = 1;
            fresh_map[idx + i] = 0;
          end
        busy_pages += r.cnt - replaced;
      end else begin
        o.page = '0;
      end
    end
    o.in_use = busy_pages[CNT_W-1:0];
    return o;
  endfunction

  // Sends one request; the expectation is queued when it is accepted.
  // The request stays driven after acceptance until the next falling edge that changes it.
  task automatic send_request(page_req_t r, bit typed, page_rsp_t want);
    page_rsp_t p;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, r.cnt, r.addr};
    s_axis_tuser  <= {r.zreq, r.fix, r.kind};
    do @(posedge clk_i); while (!s_axis_tready);
    p = allocate_page_range(r);
    expected_rsps.push_back(typed ? want : p);
  endtask

  task automatic write_register(logic idx, logic [ADDR_W-1:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_REGION_BASE) base_q = val;
    else total_q = val[CNT_W-1:0];
  endtask

  function automatic page_req_t rand_request();
    page_req_t       r;
    longint unsigned sz = region_size();
    int              pick = $urandom_range(99);
    r.kind = $urandom_range(99) < 40;
    r.fix  = $urandom_range(99) < 25;
    r.zreq = $urandom_range(1);
    r.cnt  = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(1, 24);
    if (pick < 4) r.cnt = 0;
    if (pick < 80 && sz > 0) begin
      // Inside the region: start anywhere in it, length may spill past the top.
      r.addr = base_q + $urandom_range(sz - 1);
    end else if (pick < 85) begin
      r.addr = 0;
    end else begin
      r.addr = {$urandom, $urandom};
      if ($urandom_range(1)) r.addr = base_q - $urandom_range(1, 4);
    end
    return r;
  endfunction

  // Response side: random stalls, compare with the oldest expectation.
  always @(negedge clk_i)
    m_axis_tready <= sink_calm || ($urandom_range(99) >= 11);

  always @(posedge clk_i) begin
    page_rsp_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      n_rsps++;
      if (expected_rsps.size() == 0) begin
        report("unexpected response", m_axis_tdata[35:0], 0);
      end else begin
        w = expected_rsps.pop_front();
        if (m_axis_tuser[1:0] != w.status) report("status", m_axis_tuser[1:0], w.status);
        if (m_axis_tdata[35:0] != w.page) report("result_page", m_axis_tdata[35:0], w.page);
        if (m_axis_tuser[2] != w.nz) report("need_zero", m_axis_tuser[2], w.nz);
        if (m_axis_tdata[48:36] != w.in_use)
          report("pages_in_use", m_axis_tdata[48:36], w.in_use);
      end
    end
  end

  // Directed rows, default region base 1 and 4096 pages (top page 4096).
  dir_row_t dir_rows[] = '{
    '{'{REQ_MAP, 36'd0, 13'd0, 1'b0, 1'b0}, 1'b1, '{ST_INVALID, 36'd0, 1'b0, 13'd0}},
    '{'{REQ_UNMAP, 36'd5, 13'd0, 1'b0, 1'b0}, 1'b1, '{ST_INVALID, 36'd0, 1'b0, 13'd0}},
    '{'{REQ_MAP, 36'd0, 13'd1, 1'b0, 1'b1}, 1'b1, '{ST_OK, 36'd4096, 1'b0, 13'd1}},
    '{'{REQ_MAP, 36'd0, 13'd1, 1'b0, 1'b1}, 1'b1, '{ST_OK, 36'd4095, 1'b0, 13'd2}},
    '{'{REQ_MAP, 36'd1, 13'd4097, 1'b1, 1'b0}, 1'b1, '{ST_NOMEM, 36'd0, 1'b0, 13'd2}},
    '{'{REQ_MAP, 36'd0, 13'd4096, 1'b0, 1'b0}, 1'b1, '{ST_NOMEM, 36'd0, 1'b0, 13'd2}},
    '{'{REQ_MAP, 36'd0, 13'd8191, 1'b0, 1'b0}, 1'b1, '{ST_NOMEM, 36'd0, 1'b0, 13'd2}},
    '{'{REQ_MAP, 36'hF_FFFF_FFFF, 13'd1, 1'b1, 1'b1}, 1'b1, '{ST_NOMEM, 36'd0, 1'b0, 13'd2}},
    '{'{REQ_UNMAP, 36'd4096, 13'd2, 1'b0, 1'b0}, 1'b1, '{ST_INVALID, 36'd0, 1'b0, 13'd2}},
    '{'{REQ_MAP, 36'd4095, 13'd2, 1'b1, 1'b1}, 1'b1, '{ST_OK, 36'd4095, 1'b1, 13'd2}},
    '{'{REQ_UNMAP, 36'd4095, 13'd2, 1'b0, 1'b0}, 1'b1, '{ST_OK, 36'd0, 1'b0, 13'd0}},
    '{'{REQ_MAP, 36'd4095, 13'd2, 1'b0, 1'b1}, 1'b1, '{ST_OK, 36'd4095, 1'b1, 13'd2}},
    '{'{REQ_MAP, 36'd1, 13'd10, 1'b0, 1'b1}, 1'b1, '{ST_OK, 36'd1, 1'b0, 13'd12}},
    '{'{REQ_MAP, 36'd5, 13'd3, 1'b0, 1'b0}, 1'b0, '0},
    '{'{REQ_MAP, 36'd3, 13'd8, 1'b1, 1'b1}, 1'b0, '0},
    '{'{REQ_MAP, 36'd0, 13'd4000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{REQ_UNMAP, 36'd1, 13'd4096, 1'b0, 1'b0}, 1'b1, '{ST_OK, 36'd0, 1'b0, 13'd0}},
    '{'{REQ_MAP, 36'd1, 13'd4096, 1'b1, 1'b1}, 1'b1, '{ST_OK, 36'd1, 1'b1, 13'd4096}},
    '{'{REQ_UNMAP, 36'd0, 13'd1, 1'b0, 1'b0}, 1'b1, '{ST_INVALID, 36'd0, 1'b0, 13'd4096}},
    '{'{REQ_UNMAP, 36'd1, 13'd4096, 1'b1, 1'b1}, 1'b1, '{ST_OK, 36'd0, 1'b0, 13'd0}}
  };

  // Region settings visited by the random phases; the extremes among them.
  logic [ADDR_W-1:0] bases [5] = '{36'd1, 36'hF_FFFF_F000, 36'd777, 36'd1, 36'h8_0000_0000};
  logic [CNT_W-1:0]  totals[5] = '{13'd4096, 13'd4095, 13'd64, 13'd1, 13'd8191};

  initial begin
    page_rsp_t none = '0;
    base_q = 36'd1;
    total_q = 13'd4096;
    busy_pages = 0;
    foreach (used_map[i]) begin
      used_map[i] = 0;
      fresh_map[i] = 1;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_register(CFG_REGION_BASE, bases[ph]);
        write_register(CFG_TOTAL_PAGES, {23'd0, totals[ph]});
      end else begin
        write_register(CFG_TOTAL_PAGES, 36'd0);
      end
      idle_pct  = (ph == 2) ? 0 : 11;
      sink_calm = (ph == 2);
      for (int k = 0; k < ((ph == 5) ? 50 : 360); k++) send_request(rand_request(), 0, none);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: drain, allow the block's latency, then judge.
  initial begin
    wait (stim_done);
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (n_errors == 0 && expected_rsps.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
sv/bpa_pkg.sv
sv/bpa_word_ram.sv
sv/bpa_fit.sv
sv/bitmap_page_allocator.sv
test/tb.sv
